FILE: rtl/dvcs_pkg.sv
// Shared widths and command codes for the distinct value count and sort block.
`default_nettype none

package dvcs_pkg;

    localparam int VALUE_W = 31;
    localparam int COUNT_W = 16;
    localparam int ENTRY_W = VALUE_W + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/dvcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dvcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/distinct_value_count_sort.sv
// Distinct value counter: table of values with occurrence counts, emitted sorted by count.
//
// Input channel (i_valid / o_stall): one beat carries i_command and i_value.
//   An add beat searches the table entry by entry through one RAM read port;
//   it holds o_stall while it reads the entries in turn, waits on the registered
//   read data, and then writes the count or appends the value, so the block
//   does not take a new beat before the last one is through. No output beat.
// A finish beat emits one output beat per table entry, ascending by count,
//   ties in order of first appearance. Each output beat needs a full pass over
//   the table to pick the smallest (count, index) key above the one sent last,
//   then a load of that entry into the output register; an empty table gives
//   one beat flagged empty.
// Output channel (o_valid / i_stall): results sit in an output register. While
//   the receiver stalls, the beat holds and the sequencer waits; once the last
//   beat is loaded the block takes new input even if that beat is still pending.
// Reset (synchronous, active low) empties the table, clears the running total
//   and the overflow flag, and drops any pending output beat. The RAM contents
//   are not cleared: only entries below the fill count are ever read.
// Counts and the total saturate at 65535; a new value met with a full table is
//   dropped and sets the overflow flag.
`default_nettype none

module distinct_value_count_sort #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_command,
    input  wire logic [dvcs_pkg::VALUE_W-1:0] i_value,
    // output channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [dvcs_pkg::VALUE_W-1:0] o_entry_value,
    output logic      [dvcs_pkg::COUNT_W-1:0] o_entry_count,
    output logic      [dvcs_pkg::COUNT_W-1:0] o_total_count,
    output logic                             o_table_overflowed,
    output logic                             o_empty_table,
    output logic                             o_last_entry
);

    localparam int IW = $clog2(TABLE_ENTRIES);        // entry index
    localparam int UW = $clog2(TABLE_ENTRIES + 1);    // fill count, holds the depth
    localparam int KW = dvcs_pkg::COUNT_W + IW;        // sort key: count then index
    localparam int VW = dvcs_pkg::VALUE_W;
    localparam int CW = dvcs_pkg::COUNT_W;
    localparam int EW = dvcs_pkg::ENTRY_W;
    localparam logic [UW-1:0] FULL = UW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,     // search for the value
        S_SCAN,    // pass over the table for the next key in order
        S_EMIT     // load the chosen entry into the output register
    } t_state;

    t_state         r_state;
    logic [UW-1:0]  r_used;
    logic [CW-1:0]  r_total;
    logic           r_ovf;
    logic [VW-1:0]  r_val;
    logic [UW-1:0]  r_addr;
    logic           r_rd_vld;
    logic [IW-1:0]  r_rd_idx;
    logic [UW-1:0]  r_emitted;
    logic           r_have_last;
    logic [KW-1:0]  r_last_key;
    logic           r_best_vld;
    logic [KW-1:0]  r_best_key;
    logic [VW-1:0]  r_best_val;

    logic           r_o_valid;
    logic [VW-1:0]  r_o_value;
    logic [CW-1:0]  r_o_count;
    logic [CW-1:0]  r_o_total;
    logic           r_o_ovf;
    logic           r_o_empty;
    logic           r_o_last;

    // RAM side
    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    logic [EW-1:0]  ram_wdata;
    logic           ram_re;
    logic [EW-1:0]  ram_rdata;

    logic [VW-1:0]  rd_val;
    logic [CW-1:0]  rd_cnt;
    logic [KW-1:0]  rd_key;
    logic [CW-1:0]  cnt_inc;
    logic [CW-1:0]  n_total;
    logic           add_hit;
    logic           add_miss;
    logic           scan_done;
    logic           out_free;
    logic           is_cand;
    logic           emit_last;

    assign rd_val  = ram_rdata[EW-1:CW];
    assign rd_cnt  = ram_rdata[CW-1:0];
    assign rd_key  = {rd_cnt, r_rd_idx};
    assign cnt_inc = (rd_cnt == dvcs_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
    assign n_total = (r_total == dvcs_pkg::COUNT_MAX) ? r_total : r_total + 1'b1;

    assign add_hit   = (r_state == S_ADD) && r_rd_vld && (rd_val == r_val);
    assign add_miss  = (r_state == S_ADD) && !r_rd_vld && (r_addr == r_used);
    assign scan_done = (r_state == S_SCAN) && !r_rd_vld && (r_addr == r_used);

    // entry above the last one sent and below the best seen so far this pass
    assign is_cand = r_rd_vld
                  && (!r_have_last || (rd_key > r_last_key))
                  && (!r_best_vld || (rd_key < r_best_key));

    assign out_free  = !r_o_valid || !i_stall;
    assign emit_last = (r_used == '0)
                    || ({1'b0, r_emitted} + 1'b1 == {1'b0, r_used});

    always_comb begin
        ram_re = ((r_state == S_ADD) || (r_state == S_SCAN))
              && (r_addr < r_used) && !add_hit;
        ram_we    = add_hit || (add_miss && (r_used != FULL));
        ram_waddr = add_hit ? r_rd_idx : r_used[IW-1:0];
        ram_wdata = add_hit ? {r_val, cnt_inc} : {r_val, CW'(1)};
    end

    dvcs_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_o_valid   <= 1'b0;
            r_have_last <= 1'b0;
            r_best_vld  <= 1'b0;
            r_addr      <= '0;
            r_emitted   <= '0;
        end else begin
            r_rd_vld <= ram_re;
            r_rd_idx <= r_addr[IW-1:0];
            if (ram_re) begin
                r_addr <= r_addr + 1'b1;
            end

            // in S_EMIT the load below decides the output valid
            if (r_o_valid && !i_stall && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_val       <= i_value;
                        r_addr      <= '0;
                        r_emitted   <= '0;
                        r_have_last <= 1'b0;
                        r_best_vld  <= 1'b0;
                        if (i_command == dvcs_pkg::CMD_FINISH) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_ADD;
                        end
                    end
                end
                S_ADD: begin
                    if (add_hit) begin
                        r_total <= n_total;
                        r_state <= S_IDLE;
                    end else if (add_miss) begin
                        r_total <= n_total;
                        if (r_used != FULL) begin
                            r_used <= r_used + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (is_cand) begin
                        r_best_vld <= 1'b1;
                        r_best_key <= rd_key;
                        r_best_val <= rd_val;
                    end
                    if (scan_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_last  <= emit_last;
                        if (r_used == '0) begin
                            r_o_value <= '0;
                            r_o_count <= '0;
                            r_o_total <= '0;
                            r_o_ovf   <= 1'b0;
                            r_o_empty <= 1'b1;
                        end else begin
                            r_o_value <= r_best_val;
                            r_o_count <= r_best_key[KW-1:IW];
                            r_o_total <= r_total;
                            r_o_ovf   <= r_ovf;
                            r_o_empty <= 1'b0;
                        end
                        r_last_key  <= r_best_key;
                        r_have_last <= 1'b1;
                        r_best_vld  <= 1'b0;
                        r_emitted   <= r_emitted + 1'b1;
                        r_addr      <= '0;
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_entry_value      = r_o_value;
    assign o_entry_count      = r_o_count;
    assign o_total_count      = r_o_total;
    assign o_table_overflowed = r_o_ovf;
    assign o_empty_table      = r_o_empty;
    assign o_last_entry       = r_o_last;

endmodule

`default_nettype wire
